FILE: design/rah_pkg.sv
// Package for the receive acknowledgement history tracker.
// Holds widths, outcome codes and the state and result structs.
// No dependencies.
`default_nettype none
package rah_pkg;

    localparam int SEQ_W      = 16;
    localparam int ORD_W      = 64;
    localparam int HIST_DEPTH = 32;
    localparam int OUTCOME_W  = 3;

    localparam logic [ORD_W-1:0] SEQ_MODULUS = 64'd65536;

    localparam logic [OUTCOME_W-1:0] OUT_INIT    = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ADVANCE = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_REPEAT  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_OLDER   = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_NOSEQ   = 3'd4;

    typedef struct packed {
        logic [SEQ_W-1:0]      head;
        logic [ORD_W-1:0]      ordinal;
        logic [HIST_DEPTH-1:0] history;
        logic                  ready;
    } rah_state_t;

    typedef struct packed {
        logic [ORD_W-1:0]      ordinal;
        logic [SEQ_W-1:0]      head;
        logic [HIST_DEPTH-1:0] history;
        logic                  ready;
        logic [OUTCOME_W-1:0]  outcome;
    } rah_result_t;

endpackage
`default_nettype wire

FILE: design/rah_update.sv
// Combinational step of the tracker: next state and result for one word.
// Depends on rah_pkg.
`default_nettype none
module rah_update
(
    input  wire rah_pkg::rah_state_t     state,
    input  wire logic [rah_pkg::SEQ_W-1:0] seq,
    input  wire logic                    present,
    output rah_pkg::rah_state_t          state_next,
    output rah_pkg::rah_result_t         result
);

    logic [rah_pkg::SEQ_W-1:0]      fwd;
    logic [rah_pkg::SEQ_W-1:0]      fwd_m1;
    logic [rah_pkg::ORD_W-1:0]      ord_sum;
    logic [rah_pkg::ORD_W-1:0]      ord_fresh;
    logic [rah_pkg::HIST_DEPTH-1:0] shifted;
    logic [rah_pkg::OUTCOME_W-1:0]  outcome;

    // modulus is a power of two: forward distance is a wrapping subtract
    assign fwd       = seq - state.head;
    assign fwd_m1    = fwd - rah_pkg::SEQ_W'(1);
    assign ord_sum   = state.ordinal
                     + {{(rah_pkg::ORD_W-rah_pkg::SEQ_W){fwd[rah_pkg::SEQ_W-1]}}, fwd};
    assign ord_fresh = rah_pkg::SEQ_MODULUS + rah_pkg::ORD_W'(seq);

    always_comb
    begin
        shifted = '0;
        if (fwd < rah_pkg::SEQ_W'(rah_pkg::HIST_DEPTH))
        begin
            shifted = state.history << fwd[$clog2(rah_pkg::HIST_DEPTH)-1:0];
        end
        if (fwd <= rah_pkg::SEQ_W'(rah_pkg::HIST_DEPTH))
        begin
            shifted[fwd_m1[$clog2(rah_pkg::HIST_DEPTH)-1:0]] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state;
        if (!present)
        begin
            outcome = rah_pkg::OUT_NOSEQ;
        end
        else if (!state.ready)
        begin
            outcome            = rah_pkg::OUT_INIT;
            state_next.head    = seq;
            state_next.ordinal = ord_fresh;
            state_next.history = '0;
            state_next.ready   = 1'b1;
        end
        else if (fwd == '0)
        begin
            outcome = rah_pkg::OUT_REPEAT;
        end
        else if (fwd[rah_pkg::SEQ_W-1])
        begin
            outcome = rah_pkg::OUT_OLDER;
        end
        else
        begin
            outcome            = rah_pkg::OUT_ADVANCE;
            state_next.head    = seq;
            state_next.ordinal = ord_sum;
            state_next.history = shifted;
        end
    end

    // received word's ordinal: old ordinal plus signed distance, fresh when not ready
    always_comb
    begin
        result.ordinal = state.ready ? ord_sum : ord_fresh;
        result.head    = state_next.head;
        result.history = state_next.history;
        result.ready   = state_next.ready;
        result.outcome = outcome;
    end

endmodule
`default_nettype wire

FILE: design/receive_ack_history_tracker.sv
// Receive acknowledgement history tracker: input register, update step, result register.
// Two register stages: the accepted word, then its result, each held in a register.
// Throughput: one word per cycle; m_tready low with a result held stalls both stages.
// Reset: asynchronous, active low; head, ordinal, history and ready flag clear.
// Depends on rah_pkg and rah_update.
`default_nettype none
module receive_ack_history_tracker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sequence_number
    input  wire  [0:0]  s_tuser,   // [0] sequence_present
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [119:0] m_tdata,  // [63:0] packet_ordinal_out, [79:64] head_sequence,
                                   // [111:80] history_bits, [112] ring_ready, zero pad
    output logic [2:0]  m_tuser    // [2:0] outcome
);

    logic                      in_valid_reg;
    logic [rah_pkg::SEQ_W-1:0] in_seq_reg;
    logic                      in_present_reg;
    logic                      out_valid_reg;
    rah_pkg::rah_result_t      out_reg;
    rah_pkg::rah_state_t       state_reg;
    rah_pkg::rah_state_t       state_next;
    rah_pkg::rah_result_t      result;
    logic                      step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    rah_update u_update
    (
        .state      (state_reg),
        .seq        (in_seq_reg),
        .present    (in_present_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_seq_reg     <= s_tdata;
            in_present_reg <= s_tuser[0];
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.ready, out_reg.history, out_reg.head, out_reg.ordinal};
    assign m_tuser  = out_reg.outcome;

`ifndef SYNTHESIS
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ready |=> state_reg.ready)
        else $error("ring ready flag dropped");

    a_advance_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.outcome == rah_pkg::OUT_ADVANCE
        |=> state_reg.head != $past(state_reg.head))
        else $error("advance left head unchanged");

    a_no_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && (result.outcome == rah_pkg::OUT_REPEAT || result.outcome == rah_pkg::OUT_OLDER
                 || result.outcome == rah_pkg::OUT_NOSEQ)
        |=> $stable(state_reg.head) && $stable(state_reg.history) && $stable(state_reg.ordinal))
        else $error("state changed without advance");

    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with empty stage");
`endif

endmodule
`default_nettype wire
